[sv/pgs_pkg.sv]
// Shared types and constants for the permutation generator with sign.
// No dependencies; every other file of the block but pgs_req_if imports this package.
`default_nettype none

package pgs_pkg;

   localparam int POS_W = 3;   // width of the position field of a result beat
   localparam int VAL_W = 3;   // width of the element value field
   localparam int CFG_W = 4;   // width of the element count register

   // Request kind as sorted by the front end.
   typedef enum logic {
      CMD_NEXT    = 1'b0,
      CMD_RESTART = 1'b1
   } pgs_kind_type;

   // Queued request as offered to the back end.
   typedef struct packed {
      logic         valid;
      pgs_kind_type kind;
   } pgs_cmd_type;

endpackage

`default_nettype wire

[sv/pgs_req_if.sv]
// Request channel: valid/ready plus the restart flag.
// No dependencies; it does not import pgs_pkg.
`default_nettype none

interface pgs_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

[sv/pgs_rsp_if.sv]
// Result channel: valid/ready plus one permutation element per beat.
// Depends on pgs_pkg for the field widths.
`default_nettype none

interface pgs_rsp_if import pgs_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] elem_value;
   logic             sign_negative;
   logic             exhausted;
   logic             last;

   modport source (output valid, output position, output elem_value, output sign_negative,
                   output exhausted, output last, input ready);
   modport sink   (input valid, input position, input elem_value, input sign_negative,
                   input exhausted, input last, output ready);
endinterface

`default_nettype wire

[sv/pgs_csr_if.sv]
// Configuration write channel: valid/ready plus the element count.
// Depends on pgs_pkg for the register width.
`default_nettype none

interface pgs_csr_if import pgs_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/pgs_front.sv]
// Front end: accepts request beats, sorts them by kind and queues them.
// Depends on pgs_pkg and pgs_req_if.
`default_nettype none

module pgs_front import pgs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pgs_req_if.sink    req_ch,
   input  logic       cmd_pop,
   output pgs_cmd_type cmd
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pgs_kind_type     kind_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_ch.ready = (count_ff != CNT_W'(DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = cmd_pop && (count_ff != '0);

   assign cmd.valid = (count_ff != '0);
   assign cmd.kind  = kind_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify on entry
   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff] <= req_ch.restart ? CMD_RESTART : CMD_NEXT;
      end
   end

endmodule

`default_nettype wire

[sv/pgs_back.sv]
// Back end: holds the permutation, the level cursors and the parity, steps
// Ives' enumeration and streams the result beats. Depends on pgs_pkg and the
// pgs_rsp_if / pgs_csr_if channels.
`default_nettype none

module pgs_back import pgs_pkg::*; #(
   parameter int MAX_ELEMENTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  pgs_cmd_type cmd,
   output logic        cmd_pop,
   pgs_rsp_if.source   rsp_ch,
   pgs_csr_if.sink     csr_ch
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int LVL_W = CNT_W + 1;
   localparam int N_RESET = (MAX_ELEMENTS < 8) ? MAX_ELEMENTS : 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WR_A,
      ST_WR_B,
      ST_EMIT,
      ST_EXH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] a_ff, a_in;
   logic [IDX_W-1:0] b_ff, b_in;
   logic [IDX_W-1:0] tmp_ff, tmp_in;
   logic             wrap_ff, wrap_in;
   logic             odd_ff, odd_in;
   logic             started_ff, started_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic             sign_ff, sign_in;
   logic             exh_ff, exh_in;
   logic             last_ff, last_in;

   logic [IDX_W-1:0] perm_mem [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] valid_ff;
   logic [IDX_W-1:0] cursor_ff [MAX_ELEMENTS];
   logic [IDX_W-1:0] rd_a_ff, rd_b_ff;

   logic             we;
   logic [IDX_W-1:0] wa, wd;
   logic [IDX_W-1:0] ra_a, ra_b;
   logic             clear;
   logic             cursor_we;
   logic [IDX_W-1:0] cursor_wd;
   logic             out_free;
   logic [LVL_W-1:0] lvl_span;
   logic [IDX_W-1:0] top;
   logic [IDX_W-1:0] cur;
   logic [CNT_W-1:0] n_eff;

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.position      = pos_ff;
   assign rsp_ch.elem_value    = val_ff;
   assign rsp_ch.sign_negative = sign_ff;
   assign rsp_ch.exhausted     = exh_ff;
   assign rsp_ch.last          = last_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign lvl_span = LVL_W'({i_ff, 1'b1});
   assign top      = IDX_W'(n_ff - CNT_W'(1) - CNT_W'(i_ff));
   assign cur      = cursor_ff[i_ff];

   // clamp the written count into 1 .. MAX_ELEMENTS
   always_comb begin
      if (csr_ch.data == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(csr_ch.data) > 32'(MAX_ELEMENTS)) begin
         n_eff = CNT_W'(MAX_ELEMENTS);
      end else begin
         n_eff = CNT_W'(csr_ch.data);
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      tmp_in       = tmp_ff;
      wrap_in      = wrap_ff;
      odd_in       = odd_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      pos_in       = pos_ff;
      val_in       = val_ff;
      sign_in      = sign_ff;
      exh_in       = exh_ff;
      last_in      = last_ff;
      we           = 1'b0;
      wa           = a_ff;
      wd           = rd_b_ff;
      ra_a         = k_ff;
      ra_b         = b_ff;
      clear        = 1'b0;
      cmd_pop      = 1'b0;
      cursor_we    = 1'b0;
      cursor_wd    = cur;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == CMD_RESTART || !started_ff) begin
                  clear      = 1'b1;
                  odd_in     = 1'b0;
                  started_in = 1'b1;
                  k_in       = '0;
                  ra_a       = '0;
                  state_in   = ST_EMIT;
               end else begin
                  i_in     = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (lvl_span >= LVL_W'(n_ff)) begin
               // no level left: re-arm and report
               clear      = 1'b1;
               odd_in     = 1'b0;
               started_in = 1'b0;
               state_in   = ST_EXH;
            end else if (cur < top) begin
               a_in      = cur;
               b_in      = IDX_W'(cur + 1'b1);
               ra_a      = cur;
               ra_b      = IDX_W'(cur + 1'b1);
               cursor_we = 1'b1;
               cursor_wd = IDX_W'(cur + 1'b1);
               wrap_in   = 1'b0;
               odd_in    = !odd_ff;
               state_in  = ST_WR_A;
            end else begin
               a_in      = i_ff;
               b_in      = top;
               ra_a      = i_ff;
               ra_b      = top;
               cursor_we = 1'b1;
               cursor_wd = i_ff;
               wrap_in   = 1'b1;
               odd_in    = !odd_ff;
               state_in  = ST_WR_A;
            end
         end
         ST_WR_A: begin
            we       = 1'b1;
            wa       = a_ff;
            wd       = rd_b_ff;
            tmp_in   = rd_a_ff;
            state_in = ST_WR_B;
         end
         ST_WR_B: begin
            we = 1'b1;
            wa = b_ff;
            wd = tmp_ff;
            if (wrap_ff && tmp_ff == b_ff) begin
               // moved element landed home: cascade to the next level
               i_in     = IDX_W'(i_ff + 1'b1);
               state_in = ST_CHECK;
            end else begin
               k_in     = '0;
               ra_a     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pos_in       = POS_W'(k_ff);
               val_in       = VAL_W'(rd_a_ff);
               sign_in      = odd_ff;
               exh_in       = 1'b0;
               last_in      = (CNT_W'(k_ff) == CNT_W'(n_ff - CNT_W'(1)));
               if (CNT_W'(k_ff) == CNT_W'(n_ff - CNT_W'(1))) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = IDX_W'(k_ff + 1'b1);
                  ra_a = IDX_W'(k_ff + 1'b1);
               end
            end
         end
         ST_EXH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pos_in       = '0;
               val_in       = '0;
               sign_in      = 1'b0;
               exh_in       = 1'b1;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a count write re-arms the enumeration
      if (csr_ch.valid) begin
         n_in       = n_eff;
         clear      = 1'b1;
         odd_in     = 1'b0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= CNT_W'(N_RESET);
         odd_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         odd_ff       <= odd_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff    <= i_in;
      k_ff    <= k_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      tmp_ff  <= tmp_in;
      wrap_ff <= wrap_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      sign_ff <= sign_in;
      exh_ff  <= exh_in;
      last_ff <= last_in;
   end

   // an entry that is not valid holds its own index
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int j = 0; j < MAX_ELEMENTS; j++) begin
            cursor_ff[j] <= IDX_W'(j);
         end
      end else if (cursor_we) begin
         cursor_ff[i_ff] <= cursor_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         perm_mem[wa] <= wd;
      end
      if (we && wa == ra_a) begin
         rd_a_ff <= wd;
      end else if (valid_ff[ra_a] && !clear) begin
         rd_a_ff <= perm_mem[ra_a];
      end else begin
         rd_a_ff <= ra_a;
      end
      if (we && wa == ra_b) begin
         rd_b_ff <= wd;
      end else if (valid_ff[ra_b] && !clear) begin
         rd_b_ff <= perm_mem[ra_b];
      end else begin
         rd_b_ff <= ra_b;
      end
   end

endmodule

`default_nettype wire

[sv/permutation_generator_with_sign_top.sv]
// Top level of the permutation generator with sign.
// Depends on pgs_pkg, the three channel interfaces, pgs_front and pgs_back.
`default_nettype none

// Enumerates every permutation of n elements (n from the csr channel, 1 to
// MAX_ELEMENTS, reset value the lesser of MAX_ELEMENTS and 8) by Ives'
// method. Each request beat yields one permutation as n result beats,
// position 0 first, each carrying the element value and the parity
// (sign_negative) and with last set on the final beat. The first request
// after reset, after a count write, after exhaustion or with restart set
// yields the identity, which is even. A later request makes one adjacent
// swap, or a cascade of wrap swaps that may end in an adjacent swap; the
// parity flips once per swap. When nothing is left, a single beat with
// exhausted and last set is returned (other fields zero) and the next
// request starts over. Requests queue two deep in the front end, so until
// the queue is full the request side keeps moving while the back end works
// or the result side stalls. Each level of a step passes ST_CHECK, ST_WR_A
// and ST_WR_B, as the permutation store has one write port (two writes a swap).
// A count write is taken in any cycle (csr ready is always high); the user
// must make it only while the block is idle; the block does not enforce it.

module permutation_generator_with_sign_top import pgs_pkg::*; #(
   parameter int MAX_ELEMENTS = 8
) (
   input  logic      clock,
   input  logic      reset,
   pgs_req_if.sink   req_ch,
   pgs_rsp_if.source rsp_ch,
   pgs_csr_if.sink   csr_ch
);

   // queued request between front and back
   pgs_cmd_type cmd;
   logic        cmd_pop;

   // accept and classify request beats, hold them in a short queue
   pgs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .cmd_pop (cmd_pop),
      .cmd     (cmd)
   );

   // step the enumeration and stream result beats through the output register
   pgs_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .cmd_pop (cmd_pop),
      .rsp_ch  (rsp_ch),
      .csr_ch  (csr_ch)
   );

endmodule

`default_nettype wire

[sv/pgs_checker.sv]
// Port-level checks for the permutation generator with sign, and the bind
// that attaches them to the top level. Depends on pgs_pkg.
`default_nettype none

module pgs_checker import pgs_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             csr_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] rsp_position,
   input logic [VAL_W-1:0] rsp_elem_value,
   input logic             rsp_sign_negative,
   input logic             rsp_exhausted,
   input logic             rsp_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_position, rsp_elem_value,
         rsp_sign_negative, rsp_exhausted, rsp_last}))
      else $error("result beat changed while stalled");

   // exhaustion is a zeroed, final beat
   a_exh_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |-> rsp_last && rsp_position == '0 &&
         rsp_elem_value == '0 && !rsp_sign_negative)
      else $error("exhaustion beat malformed");

   // nothing is offered straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // count writes are never back-pressured
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr ready dropped");

endmodule

bind permutation_generator_with_sign_top pgs_checker u_pgs_checker (
   .clock             (clock),
   .reset             (reset),
   .csr_ready         (csr_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_position      (rsp_ch.position),
   .rsp_elem_value    (rsp_ch.elem_value),
   .rsp_sign_negative (rsp_ch.sign_negative),
   .rsp_exhausted     (rsp_ch.exhausted),
   .rsp_last          (rsp_ch.last)
);

`default_nettype wire
